// ===== rtl/tmp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared constants and stage-to-stage word types for the profile pipeline.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int unsigned RegW = 31;
  localparam int unsigned WordW = 32;
  localparam int unsigned DistW = 33;

  localparam logic REG_MAX_RATE = 1'b0;
  localparam logic REG_ACCEL_RATE = 1'b1;

  typedef struct packed {
    logic signed [WordW-1:0] start;
    logic                    up;
    logic [DistW-1:0]        mag;
    logic [WordW-1:0]        t;
    logic [RegW-1:0]         v;
    logic [RegW-1:0]         a;
  } front_t;

  typedef struct packed {
    logic signed [WordW-1:0] start;
    logic                    up;
    logic [DistW-1:0]        mag;
    logic [WordW-1:0]        t;
    logic [RegW-1:0]         v;
    logic [RegW-1:0]         a;
    logic                    cruise;
  } cls_t;

  typedef struct packed {
    logic signed [WordW-1:0] start;
    logic                    up;
    logic [DistW-1:0]        mag;
    logic [WordW-1:0]        t;
    logic [RegW-1:0]         v;
    logic [RegW-1:0]         a;
    logic [63:0]             ta;
    logic [63:0]             t1;
  } times_t;

endpackage

// ===== rtl/tmp_divider.sv =====
// ----------------------------------------------------------------------------
// tmp_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tmp_divider #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 31,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic [NumW:1]      vld_q;
  logic [NumW-1:0]    num_q  [1:NumW];
  logic [DenW:0]      rem_q  [1:NumW];
  logic [DenW-1:0]    den_q  [1:NumW];
  logic [SideW-1:0]   side_q [1:NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic             vld_c;
    logic [NumW-1:0]  num_c;
    logic [DenW:0]    rem_c;
    logic [DenW-1:0]  den_c;
    logic [SideW-1:0] side_c;
    logic [DenW+1:0]  sh;
    logic [DenW+1:0]  df;
    if (k == 0) begin : g_head
      assign vld_c  = valid_i;
      assign num_c  = num_i;
      assign rem_c  = '0;
      assign den_c  = den_i;
      assign side_c = side_i;
    end else begin : g_body
      assign vld_c  = vld_q[k];
      assign num_c  = num_q[k];
      assign rem_c  = rem_q[k];
      assign den_c  = den_q[k];
      assign side_c = side_q[k];
    end
    assign sh = {rem_c, num_c[NumW-1]};
    assign df = sh - {2'b00, den_c};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_c;
      end
    end
    always_ff @(posedge clk_i) begin
      den_q[k+1]  <= den_c;
      side_q[k+1] <= side_c;
      if (!df[DenW+1]) begin
        rem_q[k+1] <= df[DenW:0];
        num_q[k+1] <= {num_c[NumW-2:0], 1'b1};
      end else begin
        rem_q[k+1] <= sh[DenW:0];
        num_q[k+1] <= {num_c[NumW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quo_o   = num_q[NumW];
  assign side_o  = side_q[NumW];

endmodule

// ===== rtl/tmp_sqrt.sv =====
// ----------------------------------------------------------------------------
// tmp_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tmp_sqrt #(
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [63:0]      rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      root_o,
  output logic [SideW-1:0] side_o
);

  logic [32:1]      vld_q;
  logic [63:0]      x_q    [1:32];
  logic [31:0]      r_q    [1:32];
  logic [SideW-1:0] side_q [1:32];

  for (genvar k = 0; k < 32; k++) begin : g_stage
    localparam int unsigned Sh = 62 - 2 * k;
    logic             vld_c;
    logic [63:0]      x_c;
    logic [31:0]      r_c;
    logic [SideW-1:0] side_c;
    logic [65:0]      trial;
    if (k == 0) begin : g_head
      assign vld_c  = valid_i;
      assign x_c    = rad_i;
      assign r_c    = '0;
      assign side_c = side_i;
    end else begin : g_body
      assign vld_c  = vld_q[k];
      assign x_c    = x_q[k];
      assign r_c    = r_q[k];
      assign side_c = side_q[k];
    end
    assign trial = ({34'd0, r_c} << (Sh + 2)) + (66'd1 << Sh);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_c;
      end
    end
    always_ff @(posedge clk_i) begin
      side_q[k+1] <= side_c;
      if ({2'b00, x_c} >= trial) begin
        x_q[k+1] <= x_c - trial[63:0];
        r_q[k+1] <= {r_c[30:0], 1'b1};
      end else begin
        x_q[k+1] <= x_c;
        r_q[k+1] <= {r_c[30:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[32];
  assign root_o  = r_q[32];
  assign side_o  = side_q[32];

endmodule

// ===== rtl/tmp_eval.sv =====
// ----------------------------------------------------------------------------
// tmp_eval
// Segment select, parabola and cruise terms, clamping and final position.
// ----------------------------------------------------------------------------
module tmp_eval
  import tmp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  times_t                  tm_i,
  input  logic [63:0]             c0_i,
  output logic                    valid_o,
  output logic signed [WordW-1:0] angle_o
);

  localparam logic [1:0] SEG_ACC = 2'd0;
  localparam logic [1:0] SEG_CRU = 2'd1;
  localparam logic [1:0] SEG_DEC = 2'd2;
  localparam logic [1:0] SEG_END = 2'd3;

  // stage 1: segment and parabola argument
  logic [1:0]  seg_d, seg_q;
  logic [64:0] x_d;
  logic [31:0] x_q;
  logic        xbig_q;
  times_t      s1_q;
  logic [63:0] c0_q;
  logic        v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [64:0] tsum;

  assign tsum = {1'b0, tm_i.t1} + {1'b0, tm_i.ta};

  always_comb begin
    seg_d = SEG_END;
    x_d   = '0;
    priority if ({32'd0, tm_i.t} <= tm_i.ta) begin
      seg_d = SEG_ACC;
      x_d   = {33'd0, tm_i.t};
    end else if ({32'd0, tm_i.t} <= tm_i.t1) begin
      seg_d = SEG_CRU;
    end else if ({33'd0, tm_i.t} <= tsum) begin
      seg_d = SEG_DEC;
      x_d   = tsum - {33'd0, tm_i.t};
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q  <= seg_d;
    x_q    <= x_d[31:0];
    xbig_q <= |x_d[64:32];
    s1_q   <= tm_i;
    c0_q   <= c0_i;
  end

  // stage 2: x*x and v*t
  logic [63:0] sq_q, vt_q;
  logic        big2_q;
  logic [1:0]  seg2_q;
  times_t      s2_q;
  logic [63:0] c02_q;
  always_ff @(posedge clk_i) begin
    sq_q   <= {32'd0, x_q} * {32'd0, x_q};
    vt_q   <= {33'd0, s1_q.v} * {32'd0, s1_q.t};
    big2_q <= xbig_q;
    seg2_q <= seg_q;
    s2_q   <= s1_q;
    c02_q  <= c0_q;
  end

  // stage 3: a*sq as two partial products, cruise distance
  logic [62:0] plo_q, phi_q;
  logic        big3_q;
  logic [63:0] vt3_q;
  logic [1:0]  seg3_q;
  times_t      s3_q;
  logic [63:0] c03_q;
  always_ff @(posedge clk_i) begin
    plo_q  <= {32'd0, s2_q.a} * {31'd0, sq_q[31:0]};
    phi_q  <= {32'd0, s2_q.a} * {31'd0, sq_q[63:32]};
    big3_q <= big2_q;
    vt3_q  <= {16'd0, vt_q[63:16]};
    seg3_q <= seg2_q;
    s3_q   <= s2_q;
    c03_q  <= c02_q;
  end

  // stage 4: a*sq (95 bits) and parabola term
  logic [94:0] asq;
  logic [63:0] p_d, p_q, vt4_q;
  logic [1:0]  seg4_q;
  times_t      s4_q;
  logic [63:0] c04_q;
  assign asq = {phi_q, 32'd0} + {32'd0, plo_q};
  always_comb begin
    if (big3_q || (|asq[94:64])) begin
      p_d = '1;
    end else begin
      p_d = {33'd0, asq[63:33]};
    end
  end
  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    vt4_q  <= vt3_q;
    seg4_q <= seg3_q;
    s4_q   <= s3_q;
    c04_q  <= c03_q;
  end

  // stage 5: distance and result
  logic [63:0] travel, dd;
  logic signed [34:0] res;
  assign dd = {31'd0, s4_q.mag};
  always_comb begin
    unique case (seg4_q)
      SEG_ACC: travel = p_q;
      SEG_CRU: travel = (vt4_q > c04_q) ? vt4_q - c04_q : '0;
      SEG_DEC: travel = (p_q < dd) ? dd - p_q : '0;
      default: travel = dd;
    endcase
    if (travel > dd) travel = dd;
    if (s4_q.up) res = 35'(s4_q.start) + $signed({1'b0, travel[33:0]});
    else         res = 35'(s4_q.start) - $signed({1'b0, travel[33:0]});
  end
  always_ff @(posedge clk_i) begin
    angle_o <= res[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end
  assign valid_o = v5_q;

endmodule

// ===== rtl/trapezoid_motion_profile.sv =====
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Trapezoidal / triangular position profile in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage: load max_rate (index 0) and accel_rate (index 1) through cfg_we_i,
// cfg_idx_i, cfg_data_i while the pipeline is empty. Present a query with
// start high; busy is always low, so one word is taken every cycle. Each
// query yields one profile_angle word, flagged by done_o for one cycle.
// From start to done_o a query passes the cruise-test/classify stages,
// a 64-stage divider (ta or D*2^32/A), a 32-stage square root, two
// parallel 64-stage dividers for t1 and v*v/(2a), and five evaluation
// stages. Throughput is one word per cycle.
// Reset empties the pipeline and loads both registers with 1.0. The
// receiver cannot stall, so no backpressure exists.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile
  import tmp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [WordW-1:0] start_angle_i,
  input  logic signed [WordW-1:0] target_angle_i,
  input  logic [WordW-1:0]        elapsed_time_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [RegW-1:0]         cfg_data_i,
  output logic                    done_o,
  output logic signed [WordW-1:0] profile_angle_o
);

  logic [RegW-1:0] vr_q, ar_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= RegW'(65536);
      ar_q <= RegW'(65536);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MAX_RATE) vr_q <= cfg_data_i;
      if (cfg_idx_i == REG_ACCEL_RATE) ar_q <= cfg_data_i;
    end
  end
  assign busy = 1'b0;

  // front: distance, direction
  front_t f_q;
  logic   fv_q;
  logic signed [WordW:0] diff;
  assign diff = 33'(target_angle_i) - 33'(start_angle_i);
  always_ff @(posedge clk_i) begin
    f_q.start <= start_angle_i;
    f_q.up    <= (diff > 0);
    f_q.mag   <= diff[WordW] ? DistW'(-diff) : DistW'(diff);
    f_q.t     <= elapsed_time_i;
    f_q.v     <= (vr_q == '0) ? RegW'(1) : vr_q;
    f_q.a     <= (ar_q == '0) ? RegW'(1) : ar_q;
  end

  // classify: d*a vs v*v
  cls_t c_q;
  logic cv_q;
  always_ff @(posedge clk_i) begin
    c_q.start  <= f_q.start;
    c_q.up     <= f_q.up;
    c_q.mag    <= f_q.mag;
    c_q.t      <= f_q.t;
    c_q.v      <= f_q.v;
    c_q.a      <= f_q.a;
    c_q.cruise <= ({31'd0, f_q.mag} * {33'd0, f_q.a}) >
                  ({33'd0, f_q.v} * {33'd0, f_q.v});
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0; cv_q <= 1'b0;
    end else begin
      fv_q <= start; cv_q <= fv_q;
    end
  end

  // divider 1: v<<16 / a (cruise) or d<<32 / a (triangle)
  localparam int unsigned CW = $bits(cls_t);
  logic [63:0] n1;
  assign n1 = c_q.cruise ? {17'd0, c_q.v, 16'd0} : {c_q.mag[31:0], 32'd0};
  logic        d1v;
  logic [63:0] q1;
  cls_t        c1;
  tmp_divider #(.NumW(64), .DenW(RegW), .SideW(CW)) u_div1 (
    .clk_i, .rst_ni, .valid_i(cv_q), .num_i(n1), .den_i(c_q.a), .side_i(c_q),
    .valid_o(d1v), .quo_o(q1), .side_o(c1)
  );

  // sqrt (triangle); ta quotient travels in sideband
  localparam int unsigned SW = CW + 64;
  logic        s2v;
  logic [31:0] root;
  logic [SW-1:0] s2side;
  tmp_sqrt #(.SideW(SW)) u_sqrt (
    .clk_i, .rst_ni, .valid_i(d1v), .rad_i(q1), .side_i({c1, q1}),
    .valid_o(s2v), .root_o(root), .side_o(s2side)
  );
  cls_t        c2;
  logic [63:0] q1b, ta;
  assign {c2, q1b} = s2side;
  assign ta = c2.cruise ? q1b : {32'd0, root};

  // divider 2 and 3 in parallel: t1 = d<<16 / v, c0 = v*v / (2a)
  times_t tin;
  always_comb begin
    tin.start = c2.start; tin.up = c2.up; tin.mag = c2.mag; tin.t = c2.t;
    tin.v = c2.v; tin.a = c2.a; tin.ta = ta; tin.t1 = ta;
  end
  localparam int unsigned TW = $bits(times_t) + 1;
  logic        d3v, cr3, d4v;
  logic [63:0] q3, c0;
  times_t      t3;
  logic [TW-1:0] sd3;
  logic [62:0] vv;
  assign vv = {1'b0, {31'd0, c2.v} * {31'd0, c2.v}};
  tmp_divider #(.NumW(64), .DenW(RegW+1), .SideW(TW)) u_div2 (
    .clk_i, .rst_ni, .valid_i(s2v), .num_i({15'd0, c2.mag, 16'd0}),
    .den_i({1'b0, c2.v}), .side_i({c2.cruise, tin}),
    .valid_o(d3v), .quo_o(q3), .side_o(sd3)
  );
  tmp_divider #(.NumW(64), .DenW(RegW+1), .SideW(1)) u_div3 (
    .clk_i, .rst_ni, .valid_i(s2v), .num_i({1'b0, vv}),
    .den_i({c2.a, 1'b0}), .side_i(1'b0),
    .valid_o(d4v), .quo_o(c0), .side_o()
  );
  times_t tm;
  always_comb begin
    {cr3, t3} = sd3;
    tm = t3;
    if (cr3) tm.t1 = q3;
  end

  logic unused_v;
  assign unused_v = d4v;

  tmp_eval u_eval (
    .clk_i, .rst_ni, .valid_i(d3v), .tm_i(tm), .c0_i(c0),
    .valid_o(done_o), .angle_o(profile_angle_o)
  );

endmodule

// ===== rtl/tmp_checker.sv =====
// ----------------------------------------------------------------------------
// tmp_checker
// Port-level checks for the profile block.
// ----------------------------------------------------------------------------
module tmp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_no_early: assert property (@(posedge clk_i) $fell(rst_ni) |-> ##1 !done_o)
    else $error("done right after reset");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##167 done_o)
    else $error("result missing");

endmodule

bind trapezoid_motion_profile tmp_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o
);
